/* rtl/light_level_change_detector_defines.svh */
// Assertion macros for the light level change detector.
// The macros use the top level's clock and reset ports; they need no other file.
`ifndef LIGHT_LEVEL_CHANGE_DETECTOR_DEFINES_SVH
`define LIGHT_LEVEL_CHANGE_DETECTOR_DEFINES_SVH

// Checked at every rising clock edge outside reset.
`define LLCD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define LLCD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

/* rtl/llcd_pkg.sv */
// Shared types and constants of the light level change detector.
// Used by llcd_cell, llcd_eval and light_level_change_detector; no dependencies.
`timescale 1ns / 1ps

package llcd_pkg;

   localparam int LLCD_WINDOW = 8;
   localparam int LLCD_SAMPLE_W = 10;
   localparam int LLCD_SENS_W = 9;
   localparam logic [LLCD_SENS_W-1:0] LLCD_SENS_RESET = 9'd50;
   localparam logic [LLCD_SAMPLE_W-1:0] LLCD_HIGH_LIMIT = 10'd1022;
   localparam int LLCD_MAX_LEVEL = 1023;

   typedef enum logic {
      KIND_SAMPLE    = 1'b0,
      KIND_READ_FLAG = 1'b1
   } kind_type;

   typedef logic [LLCD_SAMPLE_W-1:0] sample_type;

   // Per-cycle control shared by every cell of the window chain.
   typedef struct packed {
      logic shift;
      logic fill;
   } cell_ctrl_type;

   typedef struct packed {
      sample_type average;
      logic       change;
   } eval_result_type;

endpackage

/* rtl/light_level_change_detector.sv */
// A result is registered and presented in the cycle after its request transaction is accepted.
// Throughput: one request per cycle while no result is stalled; the running-sum update,
// reciprocal multiply, clamp and step compare all complete in the cycle of acceptance, so
// the window chain shifts or refills on every accepted sample. Reset (synchronous, active
// high) zeroes the window and its running sum, clears the change flag, empties the result
// register and sets the sensitivity to 50.
`timescale 1ns / 1ps

module light_level_change_detector #(
   parameter int WINDOW = llcd_pkg::LLCD_WINDOW
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [llcd_pkg::LLCD_SENS_W-1:0]     csr_wr_data,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [15:0]                          req_tdata,  // [9:0] light_sample
   input  logic                                 req_tuser,  // [0] kind
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [15:0]                          rsp_tdata   // [0] flag_was_set,
                                                            // [10:1] window_average,
                                                            // [11] change_now
);
   import llcd_pkg::*;

`include "light_level_change_detector_defines.svh"

   localparam int SUM_W = $clog2(LLCD_MAX_LEVEL * WINDOW + 1);

   logic [LLCD_SENS_W-1:0] sensitivity_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [SUM_W-1:0]       sum_in;
   logic [SUM_W-1:0]       sum_shifted;
   logic                   change_pending_ff;
   logic                   change_pending_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [15:0]            rsp_data_ff;
   logic [15:0]            rsp_data_in;

   logic                   accept;
   logic                   sample_accept;
   kind_type               kind;
   sample_type             sample;
   cell_ctrl_type          cell_ctrl;
   eval_result_type        eval;
   sample_type             window [WINDOW];

   assign kind = kind_type'(req_tuser);
   assign sample = req_tdata[LLCD_SAMPLE_W-1:0];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign sample_accept = accept && (kind == KIND_SAMPLE);

   // The oldest sample leaves from the end of the chain as the new one enters.
   assign sum_shifted = sum_ff - SUM_W'(window[WINDOW-1]) + SUM_W'(sample);

   llcd_eval #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_eval (
      .window_sum  (sum_shifted),
      .sample      (sample),
      .sensitivity (sensitivity_ff),
      .result      (eval)
   );

   assign cell_ctrl.shift = sample_accept && !eval.change;
   assign cell_ctrl.fill = sample_accept && eval.change;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      llcd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .prev_data ((i == 0) ? sample : window[(i == 0) ? 0 : i-1]),
         .fill_data (sample),
         .data      (window[i])
      );
   end

   always_comb begin
      sum_in = sum_ff;
      change_pending_in = change_pending_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         case (kind)
            KIND_READ_FLAG: begin
               rsp_data_in = {15'd0, change_pending_ff};
               change_pending_in = 1'b0;
            end
            default: begin
               rsp_data_in = {4'd0, eval.change, eval.average, 1'b0};
               if (eval.change) begin
                  sum_in = SUM_W'(int'(sample) * WINDOW);
                  change_pending_in = 1'b1;
               end else begin
                  sum_in = sum_shifted;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensitivity_ff <= LLCD_SENS_RESET;
         sum_ff <= '0;
         change_pending_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sensitivity_ff <= csr_wr_data;
         end
         sum_ff <= sum_in;
         change_pending_ff <= change_pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   `LLCD_ASSERT(a_stall_blocks_req, (rsp_tvalid && !rsp_tready) |-> !req_tready, "request taken while result stalled")
   `LLCD_ASSERT(a_change_sets_flag, (sample_accept && eval.change) |=> change_pending_ff, "change did not set the pending flag")
   `LLCD_ASSERT(a_read_clears_flag, (accept && (kind == KIND_READ_FLAG)) |=> !change_pending_ff, "flag read did not clear the pending flag")
   `LLCD_ASSERT(a_fill_sum, cell_ctrl.fill |=> (sum_ff == SUM_W'(int'(window[0]) * WINDOW)), "running sum disagrees with refilled window")
   `LLCD_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_tvalid, "result register not emptied by reset")

endmodule

/* rtl/llcd_cell.sv */
// One entry of the sample window chain.
// Depends on llcd_pkg for the sample and control types.
`timescale 1ns / 1ps

module llcd_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  llcd_pkg::cell_ctrl_type ctrl,
   input  llcd_pkg::sample_type   prev_data,
   input  llcd_pkg::sample_type   fill_data,
   output llcd_pkg::sample_type   data
);
   import llcd_pkg::*;

   sample_type data_ff;
   sample_type data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.fill) begin
         data_in = fill_data;
      end else if (ctrl.shift) begin
         data_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

/* rtl/llcd_eval.sv */
// Window average by reciprocal multiply, clamp to the sensitivity band and
// step test of the sample. Depends on llcd_pkg.
`timescale 1ns / 1ps

module llcd_eval #(
   parameter int WINDOW = llcd_pkg::LLCD_WINDOW,
   parameter int SUM_W  = 13
) (
   input  logic [SUM_W-1:0]                  window_sum,
   input  llcd_pkg::sample_type              sample,
   input  logic [llcd_pkg::LLCD_SENS_W-1:0]  sensitivity,
   output llcd_pkg::eval_result_type         result
);
   import llcd_pkg::*;

   // floor(n / WINDOW) == (n * RECIP) >> SHIFT for every n below 2**SUM_W.
   localparam int SHIFT = SUM_W + $clog2(WINDOW);
   localparam longint RECIP = ((longint'(1) << SHIFT) + WINDOW - 1) / WINDOW;
   localparam int RECIP_W = SUM_W + 2;
   localparam int PROD_W = SUM_W + RECIP_W;

   logic [PROD_W-1:0]        product;
   sample_type               avg_raw;
   sample_type               low_bound;
   sample_type               high_bound;
   sample_type               avg_clamped;
   logic [LLCD_SAMPLE_W:0]   sample_plus_sens;
   logic [LLCD_SAMPLE_W:0]   avg_plus_sens;

   always_comb begin
      product = PROD_W'(window_sum) * PROD_W'(RECIP_W'(RECIP));
      avg_raw = LLCD_SAMPLE_W'(product >> SHIFT);
      low_bound = LLCD_SAMPLE_W'(sensitivity) + 1'b1;
      high_bound = LLCD_HIGH_LIMIT - LLCD_SAMPLE_W'(sensitivity);
      // When the band is empty, an average below the low bound takes the low bound and any other takes the high bound.
      if (avg_raw < low_bound) begin
         avg_clamped = low_bound;
      end else if (avg_raw > high_bound) begin
         avg_clamped = high_bound;
      end else begin
         avg_clamped = avg_raw;
      end
      sample_plus_sens = {1'b0, sample} + {2'b00, sensitivity};
      avg_plus_sens = {1'b0, avg_clamped} + {2'b00, sensitivity};
      result.average = avg_clamped;
      result.change = (sample_plus_sens < {1'b0, avg_clamped}) ||
                      ({1'b0, sample} > avg_plus_sens);
   end

endmodule
